### sv/assert_macros.svh
// assertion macros shared by the heater link controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold on every rising clock edge outside reset
`define HLC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hlc assertion failed");
// condition must never be true outside reset
`define HLC_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("hlc forbidden condition seen");
`else
`define HLC_ASSERT(lbl, prop)
`define HLC_NEVER(lbl, cond)
`endif

`endif

### sv/hlc_pkg.sv
// shared types, constants and decode helpers of the heater link controller
package hlc_pkg;

  // frame store geometry
  localparam int MaxFrame = 64;
  localparam int AddrW    = $clog2(MaxFrame);

  // job queue depth between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // frame bytes and limits
  localparam logic [7:0] SyncByte0     = 8'hAA;
  localparam logic [7:0] SyncByte1     = 8'h66;
  localparam logic [7:0] LenShort      = 8'h0B;
  localparam logic [7:0] LenLong       = 8'h33;
  localparam logic [7:0] MinShortCount = 8'd15;
  localparam logic [7:0] MinLongCount  = 8'd56;
  localparam logic [4:0] LenBytePos    = 5'd3;

  // heater states and command codes
  localparam logic [7:0] HeaterOff     = 8'h00;
  localparam logic [7:0] HeaterCooling = 8'h04;
  localparam logic [7:0] CmdHdrNew     = 8'h06;
  localparam logic [7:0] CmdHdrRun     = 8'h02;
  localparam logic [7:0] ModeStop      = 8'h05;
  localparam logic [7:0] ModeCool      = 8'h02;
  localparam logic [7:0] ModeStart     = 8'h06;
  localparam logic [7:0] ModeRun       = 8'h08;
  localparam logic [7:0] StopLevel     = 8'd10;
  localparam logic [3:0] CmdLastPos    = 4'd15;

  // divide by ten via reciprocal, exact for 8-bit values
  localparam logic [15:0] Recip10      = 16'd205;
  localparam int          Recip10Shift = 11;

  // field ids
  localparam logic [3:0] FidState      = 4'd0;
  localparam logic [3:0] FidLongLast   = 4'd12;
  localparam logic [3:0] FidShortFirst = 4'd13;
  localparam logic [3:0] FidShortLast  = 4'd14;

  // result kinds
  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_REJECT = 2'd2
  } hlc_kind_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ON_REQ  = 2'd0,
    CFG_LEVEL   = 2'd1,
    CFG_TIMEOUT = 2'd2,
    CFG_PERIOD  = 2'd3
  } hlc_cfg_e;

  // back end sequencer states
  typedef enum logic [3:0] {
    B_IDLE,
    B_CLS_RD,
    B_CLS_DEC,
    B_FLD_RD,
    B_FLD_DAT,
    B_FLD_EMIT,
    B_REJ_EMIT,
    B_CMD_PREP,
    B_CMD_EMIT
  } hlc_bstate_e;

  // work handed from front to back for one tick
  typedef struct packed {
    logic       do_frame;
    logic       do_send;
    logic [7:0] count;
  } hlc_job_t;

  // where a report field lives in a long or short frame
  typedef struct packed {
    logic [4:0] pos;
    logic       is16;
    logic       x10;
    logic       sext;
  } hlc_field_t;

  function automatic hlc_field_t hlc_field_info(input logic [3:0] fid);
    hlc_field_t f;
    f = '{pos: 5'd0, is16: 1'b0, x10: 1'b0, sext: 1'b0};
    unique case (fid)
      4'd0:    f.pos = 5'd5;
      4'd1:    begin f.pos = 5'd6; f.x10 = 1'b1; end
      4'd2:    f.pos = 5'd11;
      4'd3:    f.pos = 5'd13;
      4'd4:    f.pos = 5'd14;
      4'd5:    f.pos = 5'd15;
      4'd6:    begin f.pos = 5'd16; f.is16 = 1'b1; f.sext = 1'b1; end
      4'd7:    begin f.pos = 5'd20; f.is16 = 1'b1; end
      4'd8:    f.pos = 5'd23;
      4'd9:    f.pos = 5'd24;
      4'd10:   f.pos = 5'd25;
      4'd11:   f.pos = 5'd26;
      4'd12:   begin f.pos = 5'd28; f.is16 = 1'b1; end
      4'd13:   begin f.pos = 5'd8; f.x10 = 1'b1; end
      4'd14:   f.pos = 5'd9;
      default: f.pos = 5'd0;
    endcase
    return f;
  endfunction

  // one byte of the 16-byte command frame
  function automatic logic [7:0] hlc_cmd_byte(input logic [3:0] pos, input logic [7:0] hdr,
                                              input logic [7:0] lvl, input logic [7:0] mode);
    logic [7:0] b;
    b = 8'h00;
    unique case (pos)
      4'd0:    b = SyncByte0;
      4'd1:    b = SyncByte1;
      4'd2:    b = hdr;
      4'd3:    b = LenShort;
      4'd8:    b = lvl;
      4'd9:    b = mode;
      4'd15:   b = hdr + LenShort + lvl + mode;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### sv/hlc_ram.sv
// generic single write port ram with registered read
module hlc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/hlc_fifo.sv
// short job queue between the front and back parts
module hlc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hlc_pkg::hlc_job_t job_i,
  input  logic              pop_i,
  output hlc_pkg::hlc_job_t job_o,
  output logic              full_o,
  output logic              empty_o
);
  import hlc_pkg::*;

  hlc_job_t         slot_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QPtrW:0]   fill_q, fill_d;

  // pointer and fill bookkeeping
  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 1'b1 : rptr_q;
    fill_d = fill_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= job_i;
    end
  end

  assign job_o   = slot_q[rptr_q];
  assign full_o  = (fill_q == (QPtrW+1)'(QDepth));
  assign empty_o = (fill_q == '0);

endmodule

### sv/hlc_front.sv
// front part: takes items, stores bytes, keeps the timers and queues tick jobs
module hlc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_action_i,
  input  logic [7:0]               in_byte_i,
  output logic                     in_ready_o,
  input  logic [7:0]               idle_timeout_i,
  input  logic [15:0]              send_period_i,
  input  logic                     q_full_i,
  input  logic                     q_empty_i,
  input  logic                     back_busy_i,
  output logic                     q_push_o,
  output hlc_pkg::hlc_job_t        q_job_o,
  output logic                     ram_we_o,
  output logic [hlc_pkg::AddrW-1:0] ram_waddr_o,
  output logic [7:0]               ram_wdata_o
);
  import hlc_pkg::*;

  logic [7:0]  count_q, count_d;
  logic [7:0]  idle_q, idle_d;
  logic [15:0] send_q, send_d;
  logic        accept;
  logic        is_tick;
  logic        do_frame;
  logic        do_send;
  logic [16:0] send_next;

  // bytes wait until the job queue is empty and the back part is idle
  assign in_ready_o = in_action_i ? !q_full_i : (q_empty_i && !back_busy_i);
  assign accept     = in_valid_i && in_ready_o;
  assign is_tick    = in_action_i;

  // tick decisions
  assign do_frame  = (count_q != 8'd0) && (idle_q >= idle_timeout_i);
  assign send_next = {1'b0, send_q} + 17'd1;
  assign do_send   = send_next >= {1'b0, send_period_i};

  // timer and count updates
  always_comb begin
    count_d = count_q;
    idle_d  = idle_q;
    send_d  = send_q;
    if (accept && !is_tick) begin
      if (count_q != 8'hFF) begin
        count_d = count_q + 8'd1;
      end
      idle_d = 8'd0;
    end else if (accept && is_tick) begin
      if (do_frame) begin
        count_d = 8'd0;
      end
      if (idle_q != 8'hFF) begin
        idle_d = idle_q + 8'd1;
      end
      send_d = do_send ? 16'd0 : send_next[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 8'd0;
      idle_q  <= 8'd0;
      send_q  <= 16'd0;
    end else begin
      count_q <= count_d;
      idle_q  <= idle_d;
      send_q  <= send_d;
    end
  end

  // job hand-off
  assign q_push_o = accept && is_tick && (do_frame || do_send);
  assign q_job_o  = '{do_frame: do_frame, do_send: do_send, count: count_q};

  // frame store write
  assign ram_we_o    = accept && !is_tick && ({1'b0, count_q} < 9'(MaxFrame));
  assign ram_waddr_o = count_q[AddrW-1:0];
  assign ram_wdata_o = in_byte_i;

endmodule

### sv/hlc_back.sv
// back part: decodes queued frames and sends command frames, taking a new job only when idle
module hlc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  hlc_pkg::hlc_job_t         q_job_i,
  output logic                      q_pop_o,
  output logic                      ram_re_o,
  output logic [hlc_pkg::AddrW-1:0] ram_raddr_o,
  input  logic [7:0]                ram_rdata_i,
  input  logic                      on_req_i,
  input  logic [7:0]                level_i,
  output logic                      busy_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output hlc_pkg::hlc_kind_e        out_kind_o,
  output logic [3:0]                out_id_o,
  output logic signed [16:0]        out_value_o,
  output logic [7:0]                out_tx_o,
  output logic                      out_last_o
);
  import hlc_pkg::*;

  hlc_bstate_e state_q, state_d;
  hlc_job_t    job_q, job_d;
  logic [3:0]  fid_q, fid_d;
  logic [7:0]  hi_q, hi_d;
  logic [7:0]  heater_q, heater_d;
  logic [3:0]  pos_q, pos_d;
  logic [7:0]  hdr_q, hdr_d;
  logic [7:0]  lvl_q, lvl_d;
  logic [7:0]  mode_q, mode_d;

  logic               oval_q, oval_d;
  hlc_kind_e          okind_q, okind_d;
  logic [3:0]         oid_q, oid_d;
  logic signed [16:0] oval17_q, oval17_d;
  logic [7:0]         otx_q, otx_d;
  logic               olast_q, olast_d;

  hlc_field_t  finfo;
  logic        slot;
  logic        cmd_wanted;
  logic        send_emits;
  logic        is_short;
  logic        is_long;
  logic        fld_end;
  logic [15:0] lvl_prod;
  logic [7:0]  times10;
  logic [15:0] word;

  assign finfo      = hlc_field_info(fid_q);
  assign slot       = !oval_q || out_ready_i;
  assign cmd_wanted = on_req_i || (heater_q != HeaterOff);
  assign send_emits = job_q.do_send && cmd_wanted;
  assign is_short   = (job_q.count >= MinShortCount) && (ram_rdata_i == LenShort);
  assign is_long    = (job_q.count >= MinLongCount) && (ram_rdata_i == LenLong);
  assign fld_end    = (fid_q == FidLongLast) || (fid_q == FidShortLast);
  assign lvl_prod   = 16'(level_i) * Recip10;
  assign times10    = {ram_rdata_i[4:0], 3'b000} + {ram_rdata_i[6:0], 1'b0};
  assign word       = {hi_q, ram_rdata_i};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          state_d = q_job_i.do_frame ? B_CLS_RD : B_CMD_PREP;
        end
      end
      B_CLS_RD:  state_d = B_CLS_DEC;
      B_CLS_DEC: state_d = (is_short || is_long) ? B_FLD_RD : B_REJ_EMIT;
      B_FLD_RD:  state_d = B_FLD_DAT;
      B_FLD_DAT: state_d = B_FLD_EMIT;
      B_FLD_EMIT: begin
        if (slot) begin
          if (fld_end) begin
            state_d = job_q.do_send ? B_CMD_PREP : B_IDLE;
          end else begin
            state_d = B_FLD_RD;
          end
        end
      end
      B_REJ_EMIT: begin
        if (slot) begin
          state_d = job_q.do_send ? B_CMD_PREP : B_IDLE;
        end
      end
      B_CMD_PREP: state_d = cmd_wanted ? B_CMD_EMIT : B_IDLE;
      B_CMD_EMIT: begin
        if (slot && (pos_q == CmdLastPos)) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // datapath and result register control
  always_comb begin
    q_pop_o     = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = AddrW'(finfo.pos);
    job_d       = job_q;
    fid_d       = fid_q;
    hi_d        = hi_q;
    heater_d    = heater_q;
    pos_d       = pos_q;
    hdr_d       = hdr_q;
    lvl_d       = lvl_q;
    mode_d      = mode_q;
    oval_d      = oval_q && !out_ready_i;
    okind_d     = okind_q;
    oid_d       = oid_q;
    oval17_d    = oval17_q;
    otx_d       = otx_q;
    olast_d     = olast_q;
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          job_d   = q_job_i;
        end
      end
      B_CLS_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = AddrW'(LenBytePos);
      end
      B_CLS_DEC: begin
        fid_d = is_short ? FidShortFirst : FidState;
      end
      B_FLD_RD: begin
        ram_re_o = 1'b1;
      end
      B_FLD_DAT: begin
        hi_d = ram_rdata_i;
        if (finfo.is16) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = AddrW'(finfo.pos + 5'd1);
        end
      end
      B_FLD_EMIT: begin
        if (slot) begin
          oval_d  = 1'b1;
          okind_d = KIND_REPORT;
          oid_d   = fid_q;
          otx_d   = 8'h00;
          olast_d = fld_end && !send_emits;
          if (finfo.is16) begin
            oval17_d = {finfo.sext & word[15], word};
          end else if (finfo.x10) begin
            oval17_d = {9'd0, times10};
          end else begin
            oval17_d = {9'd0, ram_rdata_i};
          end
          if (fid_q == FidState) begin
            heater_d = ram_rdata_i;
          end
          fid_d = fid_q + 4'd1;
        end
      end
      B_REJ_EMIT: begin
        if (slot) begin
          oval_d   = 1'b1;
          okind_d  = KIND_REJECT;
          oid_d    = 4'd0;
          oval17_d = '0;
          otx_d    = 8'h00;
          olast_d  = !send_emits;
        end
      end
      B_CMD_PREP: begin
        pos_d = 4'd0;
        if (!on_req_i) begin
          lvl_d = StopLevel;
          if (heater_q != HeaterCooling) begin
            hdr_d  = CmdHdrNew;
            mode_d = ModeStop;
          end else begin
            hdr_d  = CmdHdrRun;
            mode_d = ModeCool;
          end
        end else begin
          lvl_d = 8'(lvl_prod[15:Recip10Shift]);
          if (heater_q == HeaterOff) begin
            hdr_d  = CmdHdrNew;
            mode_d = ModeStart;
          end else begin
            hdr_d  = CmdHdrRun;
            mode_d = ModeRun;
          end
        end
      end
      B_CMD_EMIT: begin
        if (slot) begin
          oval_d   = 1'b1;
          okind_d  = KIND_TX;
          oid_d    = 4'd0;
          oval17_d = '0;
          otx_d    = hlc_cmd_byte(pos_q, hdr_q, lvl_q, mode_q);
          olast_d  = (pos_q == CmdLastPos);
          pos_d    = pos_q + 4'd1;
        end
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      heater_q <= HeaterOff;
      oval_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      heater_q <= heater_d;
      oval_q   <= oval_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    fid_q    <= fid_d;
    hi_q     <= hi_d;
    pos_q    <= pos_d;
    hdr_q    <= hdr_d;
    lvl_q    <= lvl_d;
    mode_q   <= mode_d;
    okind_q  <= okind_d;
    oid_q    <= oid_d;
    oval17_q <= oval17_d;
    otx_q    <= otx_d;
    olast_q  <= olast_d;
  end

  assign busy_o      = (state_q != B_IDLE);
  assign out_valid_o = oval_q;
  assign out_kind_o  = okind_q;
  assign out_id_o    = oid_q;
  assign out_value_o = oval17_q;
  assign out_tx_o    = otx_q;
  assign out_last_o  = olast_q;

endmodule

### sv/heater_link_controller_top.sv
// top level of the heater link controller
// a received byte is taken only while the job queue is empty and the back end idle; no result follows it
// a tick that closes a frame or is due to send is queued as a job; the back end takes it when idle
// each frame report reads its field from the frame store, a second byte for 16-bit fields, then emits
// command bytes are emitted one after another as the result side takes them
// asynchronous active-low reset clears counters, timers, heater state; no store clearing pass
module heater_link_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic        s_axis_tuser,  // [0] action
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [3:0] field_id, [20:4] field_value, [28:21] tx_byte
  output logic [1:0]  m_axis_tuser,  // [1:0] out_kind
  output logic        m_axis_tlast,  // last
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import hlc_pkg::*;
  `include "assert_macros.svh"

  logic        on_req_q;
  logic [7:0]  level_q;
  logic [7:0]  timeout_q;
  logic [15:0] period_q;

  hlc_job_t           push_job;
  hlc_job_t           head_job;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic               back_busy;
  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [AddrW-1:0]   ram_raddr;
  logic [7:0]         ram_rdata;
  hlc_kind_e          out_kind;
  logic [3:0]         out_id;
  logic signed [16:0] out_value;
  logic [7:0]         out_tx;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_req_q  <= 1'b0;
      level_q   <= 8'd100;
      timeout_q <= 8'd10;
      period_q  <= 16'd1000;
    end else if (cfg_valid_i) begin
      unique case (hlc_cfg_e'(cfg_index_i))
        CFG_ON_REQ:  on_req_q  <= cfg_data_i[0];
        CFG_LEVEL:   level_q   <= cfg_data_i[7:0];
        CFG_TIMEOUT: timeout_q <= cfg_data_i[7:0];
        CFG_PERIOD:  period_q  <= cfg_data_i;
        default:     on_req_q  <= on_req_q;
      endcase
    end
  end

  // front part
  hlc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_action_i    (s_axis_tuser),
    .in_byte_i      (s_axis_tdata),
    .in_ready_o     (s_axis_tready),
    .idle_timeout_i (timeout_q),
    .send_period_i  (period_q),
    .q_full_i       (q_full),
    .q_empty_i      (q_empty),
    .back_busy_i    (back_busy),
    .q_push_o       (q_push),
    .q_job_o        (push_job),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata)
  );

  // job queue
  hlc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .pop_i   (q_pop),
    .job_o   (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // frame store
  hlc_ram #(
    .Width (8),
    .Depth (MaxFrame)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // back part
  hlc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_job_i     (head_job),
    .q_pop_o     (q_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .on_req_i    (on_req_q),
    .level_i     (level_q),
    .busy_o      (back_busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_id_o    (out_id),
    .out_value_o (out_value),
    .out_tx_o    (out_tx),
    .out_last_o  (m_axis_tlast)
  );

  // result packing
  assign m_axis_tdata = {3'b000, out_tx, out_value, out_id};
  assign m_axis_tuser = out_kind;

  // checks
  `HLC_NEVER(a_store_write_while_decoding, ram_we && back_busy)
  `HLC_NEVER(a_queue_overflow, q_push && q_full)
  `HLC_NEVER(a_queue_underflow, q_pop && q_empty)
  `HLC_ASSERT(a_pop_starts_work, q_pop |=> back_busy)

endmodule

### dv/tb_top.sv
// testbench for the heater link controller: directed and random link traffic against a predictor
`timescale 1ns / 1ps

import hlc_pkg::*;

// one result item as seen on the master side
typedef struct packed {
  hlc_kind_e   kind;
  logic [3:0]  fid;
  logic [16:0] value;
  logic [7:0]  tx;
  logic        last;
} hlc_result_t;

// predicts the results of the link controller and checks what comes out
class heater_result_board;
  // register copy
  bit          on_req;
  logic [7:0]  level;
  logic [7:0]  idle_limit;
  logic [15:0] period;
  // link state copy
  logic [7:0]  frame_bytes [MaxFrame];
  logic [7:0]  rx_count;
  logic [7:0]  idle_count;
  logic [15:0] send_count;
  logic [7:0]  heater_state;
  // results of the tick being predicted, then all results still owed
  hlc_result_t tick_batch [$];
  hlc_result_t pending_results [$];
  int unsigned fail_count;

  function new();
    on_req       = 1'b0;
    level        = 8'd100;
    idle_limit   = 8'd10;
    period       = 16'd1000;
    rx_count     = '0;
    idle_count   = '0;
    send_count   = '0;
    heater_state = HeaterOff;
    fail_count   = 0;
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  function int pending();
    return pending_results.size();
  endfunction

  function void set_config(hlc_cfg_e idx, logic [15:0] data);
    case (idx)
      CFG_ON_REQ:  on_req = data[0];
      CFG_LEVEL:   level = data[7:0];
      CFG_TIMEOUT: idle_limit = data[7:0];
      CFG_PERIOD:  period = data;
      default:     ;
    endcase
  endfunction

  // bytes beyond the current frame read as zero
  function logic [7:0] rd8(int idx);
    if (idx >= rx_count || idx >= MaxFrame) return 8'h00;
    return frame_bytes[idx];
  endfunction

  function logic [15:0] rd16(int idx);
    if (idx + 1 >= rx_count || idx + 1 >= MaxFrame) return 16'h0000;
    return {frame_bytes[idx], frame_bytes[idx + 1]};
  endfunction

  function void add_result(hlc_kind_e kind, logic [3:0] fid, logic [16:0] value,
                           logic [7:0] tx);
    hlc_result_t r;
    r.kind  = kind;
    r.fid   = fid;
    r.value = value;
    r.tx    = tx;
    r.last  = 1'b0;
    tick_batch.insert(tick_batch.size(), r);
  endfunction

  // classify the gathered frame by its length byte
  function void decode_frame();
    logic [7:0]  len;
    logic [15:0] w;
    len = rd8(3);
    if (rx_count > 3 && len == LenShort && rx_count >= 15) begin
      add_result(KIND_REPORT, 4'd13, 8'(rd8(8) * 10), 8'h00);
      add_result(KIND_REPORT, 4'd14, rd8(9), 8'h00);
    end else if (rx_count > 3 && len == LenLong && rx_count >= 56) begin
      w = rd16(16);
      heater_state = rd8(5);
      add_result(KIND_REPORT, 4'd0, rd8(5), 8'h00);
      add_result(KIND_REPORT, 4'd1, 8'(rd8(6) * 10), 8'h00);
      add_result(KIND_REPORT, 4'd2, rd8(11), 8'h00);
      add_result(KIND_REPORT, 4'd3, rd8(13), 8'h00);
      add_result(KIND_REPORT, 4'd4, rd8(14), 8'h00);
      add_result(KIND_REPORT, 4'd5, rd8(15), 8'h00);
      // heat exchanger temperature is signed
      add_result(KIND_REPORT, 4'd6, {w[15], w}, 8'h00);
      add_result(KIND_REPORT, 4'd7, rd16(20), 8'h00);
      add_result(KIND_REPORT, 4'd8, rd8(23), 8'h00);
      add_result(KIND_REPORT, 4'd9, rd8(24), 8'h00);
      add_result(KIND_REPORT, 4'd10, rd8(25), 8'h00);
      add_result(KIND_REPORT, 4'd11, rd8(26), 8'h00);
      add_result(KIND_REPORT, 4'd12, rd16(28), 8'h00);
    end else begin
      add_result(KIND_REJECT, 4'd0, 17'd0, 8'h00);
    end
  endfunction

  // command frame from the on request and the heater state
  function void push_command();
    logic [7:0] hdr;
    logic [7:0] lvl;
    logic [7:0] mode;
    logic [7:0] sum;
    logic [7:0] cmd [16];
    if (!on_req) begin
      if (heater_state == HeaterOff) return;
      lvl = StopLevel;
      if (heater_state != HeaterCooling) begin
        hdr  = CmdHdrNew;
        mode = ModeStop;
      end else begin
        hdr  = CmdHdrRun;
        mode = ModeCool;
      end
    end else begin
      lvl = level / 8'd10;
      if (heater_state == HeaterOff) begin
        hdr  = CmdHdrNew;
        mode = ModeStart;
      end else begin
        hdr  = CmdHdrRun;
        mode = ModeRun;
      end
    end
    foreach (cmd[i]) cmd[i] = 8'h00;
    cmd[0] = SyncByte0;
    cmd[1] = SyncByte1;
    cmd[2] = hdr;
    cmd[3] = LenShort;
    cmd[8] = lvl;
    cmd[9] = mode;
    sum = 8'h00;
    for (int i = 2; i < 15; i++) sum = sum + cmd[i];
    cmd[15] = sum;
    foreach (cmd[i]) add_result(KIND_TX, 4'd0, 17'd0, cmd[i]);
  endfunction

  // an accepted input item: a link byte or a millisecond tick
  function void take_item(bit tick, logic [7:0] b);
    logic [16:0] nxt;
    if (!tick) begin
      if (rx_count < MaxFrame) frame_bytes[rx_count] = b;
      if (rx_count != 8'hFF) rx_count++;
      idle_count = 8'h00;
      return;
    end
    tick_batch.delete();
    if (rx_count != 0 && idle_count >= idle_limit) begin
      decode_frame();
      rx_count = 8'h00;
    end
    if (idle_count != 8'hFF) idle_count++;
    nxt = {1'b0, send_count} + 17'd1;
    if (nxt >= {1'b0, period}) begin
      send_count = 16'h0000;
      push_command();
    end else begin
      send_count = nxt[15:0];
    end
    if (tick_batch.size() > 0) tick_batch[tick_batch.size() - 1].last = 1'b1;
    foreach (tick_batch[i]) pending_results.insert(pending_results.size(), tick_batch[i]);
  endfunction

  // compare an accepted result with the oldest one owed
  task match_result(hlc_result_t got);
    hlc_result_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected result kind %0d id %0d value %h tx %h last %b",
                       got.kind, got.fid, got.value, got.tx, got.last));
      return;
    end
    want = pending_results.pop_front();
    if (got.kind !== want.kind)
      report($sformatf("kind %0d, want %0d", got.kind, want.kind));
    if (got.fid !== want.fid)
      report($sformatf("field id %0d, want %0d", got.fid, want.fid));
    if (got.value !== want.value)
      report($sformatf("field value %h, want %h (id %0d)", got.value, want.value, want.fid));
    if (got.tx !== want.tx)
      report($sformatf("tx byte %h, want %h", got.tx, want.tx));
    if (got.last !== want.last)
      report($sformatf("last %b, want %b", got.last, want.last));
  endtask
endclass

module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [15:0] cfg_data_i = 16'h0000;

  heater_result_board board = new();
  hlc_result_t        seen_result;
  bit                 no_gaps = 1'b0;
  int                 cur_timeout = 10;
  int                 sink_hold = 0;
  int                 sink_draw;
  int                 items_sent = 0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  heater_link_controller_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // result side stalls: a random hold after each accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= 0;
    end else if (sink_hold > 1) begin
      sink_hold <= sink_hold - 1;
    end else if (sink_hold == 1) begin
      sink_hold     <= 0;
      m_axis_tready <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      sink_draw = no_gaps ? 0 : $urandom_range(0, 14);
      if (sink_draw > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold     <= sink_draw;
      end
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watch all three handshakes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.set_config(hlc_cfg_e'(cfg_index_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) board.take_item(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        seen_result.kind  = hlc_kind_e'(m_axis_tuser);
        seen_result.fid   = m_axis_tdata[3:0];
        seen_result.value = m_axis_tdata[20:4];
        seen_result.tx    = m_axis_tdata[28:21];
        seen_result.last  = m_axis_tlast;
        board.match_result(seen_result);
      end
    end
  end

  // one input item, after a random gap
  task automatic push_item(bit tick, logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= tick;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    push_item(1'b0, b);
  endtask

  // the data byte is ignored on a tick, so it stays random
  task automatic send_tick();
    push_item(1'b1, 8'($urandom));
  endtask

  // write all four registers back to back, unused data bits random
  task automatic write_settings(bit on, logic [7:0] lvl, logic [7:0] tmo, logic [15:0] per);
    hlc_cfg_e    idx;
    logic [15:0] d;
    for (int k = 0; k < 4; k++) begin
      idx = hlc_cfg_e'(k);
      d   = 16'($urandom);
      case (idx)
        CFG_ON_REQ:  d[0] = on;
        CFG_LEVEL:   d[7:0] = lvl;
        CFG_TIMEOUT: d[7:0] = tmo;
        default:     d = per;
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= d;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    cur_timeout = tmo;
  endtask

  // stop sending and let every owed result and any quiet tick work drain out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    // wait for the edge on which the monitor notes the last accepted item
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_state();
    case ($urandom_range(0, 3))
      0:       return HeaterOff;
      1:       return HeaterCooling;
      default: return 8'($urandom);
    endcase
  endfunction

  // random frame bytes with a chosen length byte and state byte
  task automatic send_frame(int n, logic [7:0] len_byte, logic [7:0] state_byte);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (i == 3) b = len_byte;
      else if (i == 5) b = state_byte;
      send_byte(b);
    end
  endtask

  // enough ticks for the idle timeout to close the frame
  task automatic end_frame();
    repeat (cur_timeout + 1 + $urandom_range(0, 2)) send_tick();
  endtask

  // mostly well formed frames, the rest broken frames and stray ticks
  task automatic run_phase(int budget);
    int         stop_at;
    int         pick;
    logic [7:0] len;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) no_gaps = !no_gaps;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_frame($urandom_range(56, 68), LenLong, pick_state());
        end_frame();
      end else if (pick < 65) begin
        send_frame($urandom_range(15, 18), LenShort, 8'($urandom));
        end_frame();
      end else if (pick < 73) begin
        send_frame($urandom_range(1, 3), LenShort, 8'($urandom));
        end_frame();
      end else if (pick < 80) begin
        send_frame($urandom_range(4, 55), LenLong, pick_state());
        end_frame();
      end else if (pick < 86) begin
        send_frame($urandom_range(4, 14), LenShort, 8'($urandom));
        end_frame();
      end else if (pick < 92) begin
        do len = 8'($urandom); while (len == LenShort || len == LenLong);
        send_frame($urandom_range(4, 40), len, 8'($urandom));
        end_frame();
      end else if (pick < 96) begin
        // frame cut short of the timeout, the next bytes extend it
        send_frame($urandom_range(1, 20), 8'($urandom), 8'($urandom));
        repeat ($urandom_range(0, cur_timeout)) send_tick();
      end else begin
        repeat ($urandom_range(1, 6)) send_tick();
      end
    end
    no_gaps = 1'b0;
  endtask

  // stimulus
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero timeout and zero period, full level, heater on request
    write_settings(1'b1, 8'd255, 8'd0, 16'd0);
    send_tick();
    // short frame whose bytes swing between all zeros and all ones
    for (int i = 0; i < 15; i++) begin
      if (i == 3) send_byte(LenShort);
      else send_byte(i[0] ? 8'hFF : 8'h00);
    end
    send_tick();
    // one byte frame is rejected
    send_byte(8'h5A);
    send_tick();
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       write_settings(1'b0, 8'd0, 8'd1, 16'd1);
        1:       write_settings(1'b1, 8'd99, 8'd3, 16'($urandom_range(2, 30)));
        default: write_settings(1'($urandom), $urandom_range(0, 1) ? 8'($urandom) : 8'd10,
                                8'($urandom_range(0, 5)), 16'($urandom_range(0, 24)));
      endcase
      run_phase(25);
      drain();
    end

    // longest period: the byte count saturates on a frame far beyond the store
    write_settings(1'($urandom), 8'd255, 8'd2, 16'hFFFF);
    send_frame(256, LenLong, pick_state());
    end_frame();
    drain();

    // the heater state left behind drives one more random phase
    write_settings(1'($urandom), 8'($urandom), 8'd2, 16'd4);
    run_phase(25);
    drain();

    if (board.fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
